@@ design/wvt_pkg.sv @@
package wvt_pkg;

   localparam int JOINT_COUNT    = 3;
   localparam int WAYPOINT_DEPTH = 16;

   localparam int POS_W   = 15;
   localparam int ERR_W   = POS_W + 1;
   localparam int MAG_W   = POS_W;
   localparam int ATT_W   = 16;
   localparam int SPD_W   = 8;
   localparam int CMD_W   = 17;
   localparam int STAT_W  = 3;
   localparam int SUM_W   = ATT_W + 2;
   localparam int PROD1_W = ATT_W + SPD_W;
   localparam int DIVN_W  = 40;
   localparam int DIVD_W  = 24;
   localparam int STEP_W  = 6;
   localparam int DIV_STEPS = DIVN_W;

   localparam int IDX_W   = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
   localparam int CNT_W   = $clog2(WAYPOINT_DEPTH + 1);

   // reciprocal multiply for mean = floor(sum / JOINT_COUNT)
   localparam int MEAN_SH  = 20;
   localparam int MEAN_MUL = ((1 << MEAN_SH) + JOINT_COUNT - 1) / JOINT_COUNT;
   localparam int MEAN_MW  = MEAN_SH + 1;
   // reciprocal multiply for threshold / 10
   localparam int THR_SH   = 19;
   localparam int THR_MUL  = ((1 << THR_SH) + 9) / 10;
   localparam int THR_MW   = 17;

   typedef enum logic [STAT_W-1:0] {
      ST_STORED   = 3'd0,
      ST_TRACKING = 3'd1,
      ST_ADVANCED = 3'd2,
      ST_FINISHED = 3'd3,
      ST_AT_TGT   = 3'd4,
      ST_REJECT   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_FACTOR    = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_SPEED     = 2'd2
   } reg_index_type;

   localparam logic KIND_LOAD = 1'b0;

   typedef struct packed {
      logic load_err;
      logic load_t;
      logic load_q;
      logic step;
      logic att;
      logic mul1;
      logic mul2;
   } lane_ctl_type;

   function automatic logic [ATT_W-1:0] att_rom(input logic [5:0] k);
      logic [ATT_W-1:0] v;
      unique case (k)
         6'd0:  v = 16'd0;
         6'd1:  v = 16'd5912;
         6'd2:  v = 16'd17317;
         6'd3:  v = 16'd28978;
         6'd4:  v = 16'd38928;
         6'd5:  v = 16'd46708;
         6'd6:  v = 16'd52485;
         6'd7:  v = 16'd56630;
         6'd8:  v = 16'd59534;
         6'd9:  v = 16'd61532;
         6'd10: v = 16'd62887;
         6'd11: v = 16'd63795;
         6'd12: v = 16'd64399;
         6'd13: v = 16'd64797;
         6'd14: v = 16'd65058;
         6'd15: v = 16'd65228;
         6'd16: v = 16'd65338;
         6'd17: v = 16'd65409;
         6'd18: v = 16'd65455;
         6'd19: v = 16'd65484;
         6'd20: v = 16'd65503;
         6'd21: v = 16'd65515;
         6'd22: v = 16'd65523;
         6'd23: v = 16'd65528;
         6'd24: v = 16'd65531;
         6'd25: v = 16'd65533;
         6'd26: v = 16'd65534;
         default: v = 16'd65535;
      endcase
      return v;
   endfunction

endpackage

@@ design/waypoint_velocity_tracker_unit.sv @@
// sequence: a load or a rejected tick goes from idle straight to the final state; a full
// tick runs read, error, a 40-step restoring division per lane, attenuation, the two
// multiplies, quotient load, a second such division and the decision; one word is in
// flight at a time, the final state waiting while the receiver holds the output word
// reset: synchronous active high; clears the waypoint count, target, done flag, the
// output valid and loads the register defaults; waypoint entries stay undefined
module waypoint_velocity_tracker_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [14:0]                req_joint_a,
   input  logic [14:0]                req_joint_b,
   input  logic [14:0]                req_joint_c,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_status,
   output logic [16:0]                rsp_cmd_a,
   output logic [16:0]                rsp_cmd_b,
   output logic [16:0]                rsp_cmd_c,
   output logic [15:0]                rsp_mean_atten,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [15:0]                csr_data
);

   localparam int JC = wvt_pkg::JOINT_COUNT;

   // one-hot sequencer
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_READ   = 11'b00000000010,
      S_ERR    = 11'b00000000100,
      S_DIV1   = 11'b00000001000,
      S_ATT    = 11'b00000010000,
      S_MUL1   = 11'b00000100000,
      S_MUL2   = 11'b00001000000,
      S_QLOAD  = 11'b00010000000,
      S_DIV2   = 11'b00100000000,
      S_DECIDE = 11'b01000000000,
      S_FIN    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [15:0]                factor_ff;
   logic [15:0]                thresh_ff;
   logic [wvt_pkg::SPD_W-1:0]  speed_ff;

   // waypoint bookkeeping
   logic [wvt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [wvt_pkg::IDX_W-1:0]  target_ff, target_in;
   logic                       done_ff, done_in;

   // waypoint memory with registered read
   logic [JC-1:0][wvt_pkg::POS_W-1:0] wp_mem [wvt_pkg::WAYPOINT_DEPTH];
   logic [JC-1:0][wvt_pkg::POS_W-1:0] rd_ff;
   logic [2:0][wvt_pkg::POS_W-1:0]    req_pos;
   logic [JC-1:0][wvt_pkg::POS_W-1:0] meas_ff;

   logic                       req_fire;
   logic                       mem_we;
   logic                       mem_re;

   // lanes and merge
   wvt_pkg::lane_ctl_type      lane_ctl;
   logic [wvt_pkg::MAG_W-1:0]  lane_mag [JC];
   logic [wvt_pkg::ATT_W-1:0]  lane_att [JC];
   logic [wvt_pkg::CMD_W-1:0]  lane_cmd [JC];
   logic [wvt_pkg::MAG_W-1:0]  maxe_ff, maxe_in;
   logic [wvt_pkg::SUM_W-1:0]  sum_in;
   logic [wvt_pkg::SUM_W-1:0]  sum_ff;
   logic [wvt_pkg::STEP_W-1:0] step_ff, step_in;

   logic [wvt_pkg::SUM_W+wvt_pkg::MEAN_MW-1:0] mean_prod;
   logic [wvt_pkg::ATT_W-1:0]  mean_val;
   logic [15+wvt_pkg::THR_MW:0] thr_prod;
   logic [15:0]                thr10;

   // pending result, moved to the output word when it is free
   wvt_pkg::status_type        res_status_ff, res_status_in;
   logic [2:0][wvt_pkg::CMD_W-1:0] res_cmd_ff, res_cmd_in;
   logic [wvt_pkg::ATT_W-1:0]  res_mean_ff, res_mean_in;

   logic                       rsp_valid_ff;
   wvt_pkg::status_type        rsp_status_ff;
   logic [2:0][wvt_pkg::CMD_W-1:0] rsp_cmd_ff;
   logic [wvt_pkg::ATT_W-1:0]  rsp_mean_ff;
   logic                       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_pos[0] = req_joint_a;
   assign req_pos[1] = req_joint_b;
   assign req_pos[2] = req_joint_c;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= 16'd2560;
         thresh_ff <= 16'd6554;
         speed_ff  <= 8'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wvt_pkg::REG_FACTOR:    factor_ff <= csr_data;
            wvt_pkg::REG_THRESHOLD: thresh_ff <= csr_data;
            wvt_pkg::REG_SPEED:     speed_ff  <= csr_data[wvt_pkg::SPD_W-1:0];
            default: ;
         endcase
      end
   end

   // memory port: append on load, read the current target on tick
   assign mem_we = req_fire && (req_kind == wvt_pkg::KIND_LOAD)
                && (count_ff < wvt_pkg::CNT_W'(wvt_pkg::WAYPOINT_DEPTH));
   assign mem_re = req_fire && (req_kind != wvt_pkg::KIND_LOAD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wp_mem[count_ff[wvt_pkg::IDX_W-1:0]] <= req_pos[JC-1:0];
      end
      if (mem_re) begin
         rd_ff   <= wp_mem[target_ff];
         meas_ff <= req_pos[JC-1:0];
      end
   end

   // joint lanes
   for (genvar j = 0; j < JC; j++) begin : g_lane
      wvt_lane u_lane (
         .clock        (clock),
         .ctl          (lane_ctl),
         .wp_pos       (rd_ff[j]),
         .meas_pos     (meas_ff[j]),
         .atten_factor (factor_ff),
         .max_speed    (speed_ff),
         .max_mag      (maxe_ff),
         .mag          (lane_mag[j]),
         .att          (lane_att[j]),
         .cmd          (lane_cmd[j])
      );
   end

   // merge: largest error and attenuation sum across lanes
   always_comb begin
      maxe_in = '0;
      sum_in  = '0;
      for (int j = 0; j < JC; j++) begin
         if (lane_mag[j] > maxe_in) begin
            maxe_in = lane_mag[j];
         end
         sum_in = sum_in + wvt_pkg::SUM_W'(lane_att[j]);
      end
   end

   // mean by reciprocal multiply, threshold over ten likewise
   assign mean_prod = sum_ff * wvt_pkg::MEAN_MW'(wvt_pkg::MEAN_MUL);
   assign mean_val  = wvt_pkg::ATT_W'(mean_prod >> wvt_pkg::MEAN_SH);
   assign thr_prod  = thresh_ff * wvt_pkg::THR_MW'(wvt_pkg::THR_MUL);
   assign thr10     = 16'(thr_prod >> wvt_pkg::THR_SH);

   always_comb begin
      lane_ctl          = '0;
      lane_ctl.load_err = (state_ff == S_READ);
      lane_ctl.load_t   = (state_ff == S_ERR);
      lane_ctl.load_q   = (state_ff == S_QLOAD);
      lane_ctl.step     = (state_ff == S_DIV1) || (state_ff == S_DIV2);
      lane_ctl.att      = (state_ff == S_ATT);
      lane_ctl.mul1     = (state_ff == S_MUL1);
      lane_ctl.mul2     = (state_ff == S_MUL2);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      done_in       = done_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_cmd_in    = res_cmd_ff;
      res_mean_in   = res_mean_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_cmd_in  = '0;
               res_mean_in = '0;
               state_in    = S_FIN;
               if (req_kind == wvt_pkg::KIND_LOAD) begin
                  if (mem_we) begin
                     count_in      = count_ff + 1'b1;
                     res_status_in = wvt_pkg::ST_STORED;
                  end else begin
                     res_status_in = wvt_pkg::ST_REJECT;
                  end
               end else if (done_ff) begin
                  res_status_in = wvt_pkg::ST_FINISHED;
               end else if (count_ff == '0
                            || wvt_pkg::CNT_W'(target_ff) >= count_ff) begin
                  res_status_in = wvt_pkg::ST_REJECT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ:  state_in = S_ERR;
         S_ERR: begin
            step_in  = '0;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            step_in = step_ff + 1'b1;
            if (step_ff == wvt_pkg::STEP_W'(wvt_pkg::DIV_STEPS - 1)) begin
               state_in = S_ATT;
            end
         end
         S_ATT:   state_in = S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_QLOAD;
         S_QLOAD: begin
            step_in  = '0;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            step_in = step_ff + 1'b1;
            if (step_ff == wvt_pkg::STEP_W'(wvt_pkg::DIV_STEPS - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_mean_in = mean_val;
            res_cmd_in  = '0;
            // zero error leaves all commands at zero
            if (maxe_ff != '0) begin
               for (int j = 0; j < JC; j++) begin
                  res_cmd_in[j] = lane_cmd[j];
               end
            end
            priority if (mean_val > thresh_ff) begin
               res_status_in = wvt_pkg::ST_TRACKING;
            end else if (wvt_pkg::CNT_W'(target_ff) + 1'b1 < count_ff) begin
               target_in     = target_ff + 1'b1;
               res_status_in = wvt_pkg::ST_ADVANCED;
            end else if (mean_val <= thr10) begin
               // last waypoint reached closely enough: stop for good
               done_in       = 1'b1;
               res_status_in = wvt_pkg::ST_FINISHED;
               res_cmd_in    = '0;
            end else begin
               res_status_in = wvt_pkg::ST_AT_TGT;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         target_ff    <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         target_ff <= target_in;
         done_ff   <= done_in;
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_cmd_ff    <= res_cmd_in;
      res_mean_ff   <= res_mean_in;
      if (state_ff == S_ERR) begin
         maxe_ff <= maxe_in;
      end
      if (state_ff == S_MUL1) begin
         sum_ff <= sum_in;
      end
      if (state_ff == S_FIN && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_cmd_ff    <= res_cmd_ff;
         rsp_mean_ff   <= res_mean_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cmd_a      = rsp_cmd_ff[0];
   assign rsp_cmd_b      = rsp_cmd_ff[1];
   assign rsp_cmd_c      = rsp_cmd_ff[2];
   assign rsp_mean_atten = rsp_mean_ff;

   // target always points inside the stored list
   a_target_in_list: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> wvt_pkg::CNT_W'(target_ff) < count_ff)
      else $error("target index beyond stored waypoints");

   // done flag is sticky until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("done flag cleared without reset");

   // a new output word only comes from the final state
   a_word_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("output word raised outside final state");

endmodule

@@ design/wvt_lane.sv @@
module wvt_lane (
   input  logic                         clock,
   input  wvt_pkg::lane_ctl_type        ctl,
   input  logic [wvt_pkg::POS_W-1:0]    wp_pos,
   input  logic [wvt_pkg::POS_W-1:0]    meas_pos,
   input  logic [15:0]                  atten_factor,
   input  logic [wvt_pkg::SPD_W-1:0]    max_speed,
   input  logic [wvt_pkg::MAG_W-1:0]    max_mag,
   output logic [wvt_pkg::MAG_W-1:0]    mag,
   output logic [wvt_pkg::ATT_W-1:0]    att,
   output logic [wvt_pkg::CMD_W-1:0]    cmd
);

   logic signed [wvt_pkg::ERR_W-1:0] err_ff, err_in;
   logic [wvt_pkg::ERR_W-1:0]        abs_err;
   logic [wvt_pkg::ATT_W-1:0]        att_ff, att_in;
   logic [wvt_pkg::PROD1_W-1:0]      prod1_ff;
   logic [wvt_pkg::DIVN_W-2:0]       prod2_ff;
   logic [wvt_pkg::DIVN_W-1:0]       quo_ff;
   logic [wvt_pkg::DIVD_W-1:0]       rem_ff;
   logic [wvt_pkg::DIVD_W-1:0]       div_ff;
   logic [wvt_pkg::DIVD_W:0]         rem_sh;
   logic                             q_bit;
   logic [4:0]                       idx;
   logic [6:0]                       frac;
   logic                             sat;
   logic [wvt_pkg::ATT_W-1:0]        lo, hi, diff;
   logic [22:0]                      interp;
   logic [wvt_pkg::CMD_W-1:0]        q17;

   assign err_in  = $signed({wp_pos[wvt_pkg::POS_W-1], wp_pos})
                  - $signed({meas_pos[wvt_pkg::POS_W-1], meas_pos});
   assign abs_err = err_ff[wvt_pkg::ERR_W-1] ? (~err_ff + 1'b1) : err_ff;
   assign mag     = abs_err[wvt_pkg::MAG_W-1:0];

   // restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff, quo_ff[wvt_pkg::DIVN_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, div_ff});

   // table lookup with linear interpolation between half steps of t
   assign idx    = quo_ff[11:7];
   assign frac   = quo_ff[6:0];
   assign sat    = |quo_ff[wvt_pkg::DIVN_W-1:12];
   assign lo     = wvt_pkg::att_rom({1'b0, idx});
   assign hi     = wvt_pkg::att_rom({1'b0, idx} + 6'd1);
   assign diff   = hi - lo;
   assign interp = diff * frac + 23'd64;

   always_comb begin
      if (mag == '0) begin
         att_in = '0;
      end else if (atten_factor == '0 || sat) begin
         att_in = '1;
      end else begin
         att_in = lo + interp[22:7];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_err) begin
         err_ff <= err_in;
      end
      if (ctl.load_t) begin
         quo_ff <= {{(wvt_pkg::DIVN_W-wvt_pkg::MAG_W-10){1'b0}}, mag, 10'd0};
         div_ff <= {{(wvt_pkg::DIVD_W-16){1'b0}}, atten_factor};
         rem_ff <= '0;
      end else if (ctl.load_q) begin
         quo_ff <= {1'b0, prod2_ff}
                 + {{(wvt_pkg::DIVN_W-wvt_pkg::MAG_W-7){1'b0}}, max_mag, 7'd0};
         div_ff <= {{(wvt_pkg::DIVD_W-wvt_pkg::MAG_W-8){1'b0}}, max_mag, 8'd0};
         rem_ff <= '0;
      end else if (ctl.step) begin
         rem_ff <= q_bit ? (rem_sh[wvt_pkg::DIVD_W-1:0] - div_ff)
                         : rem_sh[wvt_pkg::DIVD_W-1:0];
         quo_ff <= {quo_ff[wvt_pkg::DIVN_W-2:0], q_bit};
      end
      if (ctl.att) begin
         att_ff <= att_in;
      end
      if (ctl.mul1) begin
         prod1_ff <= att_ff * max_speed;
      end
      if (ctl.mul2) begin
         prod2_ff <= prod1_ff * mag;
      end
   end

   assign att = att_ff;
   assign q17 = quo_ff[wvt_pkg::CMD_W-1:0];
   assign cmd = err_ff[wvt_pkg::ERR_W-1] ? (~q17 + 1'b1) : q17;

endmodule
